// File: design/ccs_pkg.sv
// Package with the types, constants and byte handling functions of the comment stripper.
`timescale 1ns / 1ps

package ccs_pkg;

	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;

	// Result queue: four entries, so two free slots always cover one transfer.
	localparam int RES_DEPTH = 4;
	localparam int RES_AW    = 2;
	localparam int RES_CW    = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last;
	} src_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       end_of_text;
	} res_item_t;

	typedef struct packed {
		logic line;
		logic block;
		logic blocked;
	} flags_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] ch;
		flags_t     flags;
	} single_t;

	function automatic logic is_white(input logic [7:0] c);
		return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
	endfunction

	// Handles one byte that is not part of a two-byte mark.
	function automatic single_t take_single(input logic [7:0] c, input flags_t f);
		single_t r;
		r.emit  = 1'b0;
		r.ch    = 8'h00;
		r.flags = f;
		if (f.line) begin
			if (c == CH_NEWLINE)
				r.flags.line = 1'b0;
		end else if (!f.block) begin
			if (is_white(c)) begin
				if (!f.blocked) begin
					r.emit          = 1'b1;
					r.ch            = CH_SPACE;
					r.flags.blocked = 1'b1;
				end
			end else begin
				r.emit          = 1'b1;
				r.ch            = c;
				r.flags.blocked = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

// File: design/comment_strip_space_collapse_top.sv
// Top level of the comment stripper with whitespace collapsing.
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// src     | src_valid, src_stall | src_item: in_byte, last
// res     | res_valid, res_stall | res_item: out_byte, has_byte, end_of_text
//
// One byte is taken per cycle while src_stall is low. The lookahead byte and
// the comment flags are updated at the transfer, and the results go into a
// four-entry result queue whose head drives the res channel, so every result
// is registered. src_stall rises only when fewer than two queue slots are free,
// which happens only when res is stalled. arst_n clears the flags, the held byte
// state and the queue; no clearing pass is needed.

module comment_strip_space_collapse_top
	import ccs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_item_t src_item,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res_item
);

	// Lookahead byte and comment state.
	logic [7:0] held_byte_q;
	logic       held_valid_q;
	flags_t     flags_q;

	// Result queue.
	res_item_t         queue_q [RES_DEPTH];
	logic [RES_AW-1:0] wr_ptr_q;
	logic [RES_AW-1:0] rd_ptr_q;
	logic [RES_CW-1:0] count_q;

	logic       take;
	logic       pop;
	logic [7:0] held_byte_d;
	logic       held_valid_d;
	flags_t     flags_d;
	single_t    first;
	single_t    second;
	flags_t     pair_flags;
	logic [7:0] b;
	logic [1:0] npush;
	res_item_t  push0;
	res_item_t  push1;

	assign src_stall = (count_q > RES_CW'(RES_DEPTH - 2));
	assign take      = src_valid && !src_stall;
	assign res_valid = (count_q != '0);
	assign pop       = res_valid && !res_stall;
	assign res_item  = queue_q[rd_ptr_q];
	assign b         = src_item.in_byte;

	// The pair formed by the held byte and the new byte is resolved first. On
	// the last byte, the byte still held afterwards is flushed as a single byte.
	always_comb begin
		first        = '0;
		pair_flags   = flags_q;
		held_byte_d  = b;
		held_valid_d = 1'b1;
		if (held_valid_q) begin
			if (flags_q.line) begin
				first      = take_single(held_byte_q, flags_q);
				pair_flags = first.flags;
			end else if (held_byte_q == CH_SLASH && b == CH_SLASH) begin
				// A line comment opens even inside a block comment.
				pair_flags.line = 1'b1;
			end else if (held_byte_q == CH_SLASH && b == CH_STAR) begin
				pair_flags.block = 1'b1;
				held_valid_d     = 1'b0;
				held_byte_d      = 8'h00;
			end else if (held_byte_q == CH_STAR && b == CH_SLASH) begin
				// The closing mark is dropped even with no block comment open.
				pair_flags.block = 1'b0;
				held_valid_d     = 1'b0;
				held_byte_d      = 8'h00;
			end else begin
				first      = take_single(held_byte_q, flags_q);
				pair_flags = first.flags;
			end
		end

		second = '0;
		if (held_valid_d)
			second = take_single(held_byte_d, pair_flags);

		flags_d = pair_flags;
		npush   = 2'd0;
		push0   = '0;
		push1   = '0;
		if (!src_item.last) begin
			if (first.emit) begin
				npush = 2'd1;
				push0 = '{out_byte: first.ch, has_byte: 1'b1, end_of_text: 1'b0};
			end
		end else begin
			// End of text: the flags and the held byte return to the state after reset.
			held_byte_d  = 8'h00;
			held_valid_d = 1'b0;
			flags_d      = '{line: 1'b0, block: 1'b0, blocked: 1'b1};
			if (first.emit && second.emit) begin
				npush = 2'd2;
				push0 = '{out_byte: first.ch, has_byte: 1'b1, end_of_text: 1'b0};
				push1 = '{out_byte: second.ch, has_byte: 1'b1, end_of_text: 1'b1};
			end else if (first.emit) begin
				npush = 2'd1;
				push0 = '{out_byte: first.ch, has_byte: 1'b1, end_of_text: 1'b1};
			end else if (second.emit) begin
				npush = 2'd1;
				push0 = '{out_byte: second.ch, has_byte: 1'b1, end_of_text: 1'b1};
			end else begin
				npush = 2'd1;
				push0 = '{out_byte: 8'h00, has_byte: 1'b0, end_of_text: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q  <= 8'h00;
			held_valid_q <= 1'b0;
			flags_q      <= '{line: 1'b0, block: 1'b0, blocked: 1'b1};
		end else if (take) begin
			held_byte_q  <= held_byte_d;
			held_valid_q <= held_valid_d;
			flags_q      <= flags_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (take)
				wr_ptr_q <= wr_ptr_q + RES_AW'(npush);
			if (pop)
				rd_ptr_q <= rd_ptr_q + RES_AW'(1);
			count_q <= count_q + (take ? RES_CW'(npush) : RES_CW'(0))
				- (pop ? RES_CW'(1) : RES_CW'(0));
		end
	end

	// Queue entries are payload only.
	always_ff @(posedge clk) begin
		if (take && npush != 2'd0)
			queue_q[wr_ptr_q] <= push0;
		if (take && npush == 2'd2)
			queue_q[wr_ptr_q + RES_AW'(1)] <= push1;
	end

endmodule

// File: design/ccs_checker.sv
// Port checker for the comment stripper and its bind to the top level.
`timescale 1ns / 1ps

module ccs_checker
	import ccs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      src_valid,
	input logic      src_stall,
	input src_item_t src_item,
	input logic      res_valid,
	input logic      res_stall,
	input res_item_t res_item
);

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("stalled result changed");

	// The last byte of a text always leaves at least one result pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall && src_item.last |=> res_valid)
		else $error("end of text produced no result");

	// A result without a byte is only the end result of a text.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.has_byte |-> res_item.end_of_text)
		else $error("empty result that is not the end of text");

	// A result without a byte carries a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.has_byte |-> res_item.out_byte == 8'h00)
		else $error("empty result with a nonzero byte");

endmodule

bind comment_strip_space_collapse_top ccs_checker u_ccs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.src_item  (src_item),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);

// File: tb/testbench.sv
// Self-checking testbench for the comment stripper with whitespace collapsing.
`timescale 1ns / 1ps

// The bench sends whole texts, one byte per transfer, with last set on the
// final byte. A small class keeps its own lookahead byte and comment flags.
// For every accepted source transfer it works out the result transfers that
// must follow and queues them. Every accepted result transfer is checked,
// field by field, against the oldest queued one.
//
// A short directed set comes first. It covers the byte extremes, whitespace
// runs at the start and the end, and line comments inside block comments. It
// also covers nested opens, a close with no open comment, and texts that end
// inside a line or a block comment. Random texts follow, built from words,
// whitespace runs, comments, stray marks and noise bytes. Both channels idle
// at random, and one stretch of texts runs with no random idling.

module testbench;
	import ccs_pkg::*;

	localparam int RANDOM_ITEMS = 1450;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int PRINT_LIMIT  = 40;

	// Predicts the kept bytes of the text stream and checks the results.
	class stripped_stream;
		logic [7:0] held;
		bit         held_ok;
		bit         in_block;
		bit         in_line;
		bit         no_space;
		logic [7:0] kept[2];
		int         n_kept;
		res_item_t  due_results[$];
		int         mismatch_count;
		int         results_seen;
		int         bytes_kept;
		int         texts_ended;

		function new();
			clear_flags();
		endfunction

		function void clear_flags();
			held     = 8'h00;
			held_ok  = 1'b0;
			in_block = 1'b0;
			in_line  = 1'b0;
			no_space = 1'b1;
		endfunction

		function bit is_blank(logic [7:0] c);
			return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
		endfunction

		// A byte that is not part of a two-byte mark.
		function void lone_byte(logic [7:0] c);
			if (in_line) begin
				if (c == CH_NEWLINE)
					in_line = 1'b0;
			end else if (!in_block) begin
				if (is_blank(c)) begin
					if (!no_space) begin
						kept[n_kept++] = CH_SPACE;
						no_space = 1'b1;
					end
				end else begin
					kept[n_kept++] = c;
					no_space = 1'b0;
				end
			end
		endfunction

		function void take_source(src_item_t it);
			res_item_t r;
			n_kept = 0;
			if (!held_ok) begin
				held    = it.in_byte;
				held_ok = 1'b1;
			end else if (in_line) begin
				// Marks mean nothing inside a line comment.
				lone_byte(held);
				held = it.in_byte;
			end else if (held == CH_SLASH && it.in_byte == CH_SLASH) begin
				in_line = 1'b1;
				held    = it.in_byte;
			end else if (held == CH_SLASH && it.in_byte == CH_STAR) begin
				in_block = 1'b1;
				held_ok  = 1'b0;
				held     = 8'h00;
			end else if (held == CH_STAR && it.in_byte == CH_SLASH) begin
				// A close mark is dropped whether or not a comment is open.
				in_block = 1'b0;
				held_ok  = 1'b0;
				held     = 8'h00;
			end else begin
				lone_byte(held);
				held = it.in_byte;
			end

			if (!it.last) begin
				if (n_kept > 0) begin
					r.out_byte    = kept[0];
					r.has_byte    = 1'b1;
					r.end_of_text = 1'b0;
					due_results.push_back(r);
				end
				return;
			end

			// End of text: flush the lookahead, then start over.
			if (held_ok)
				lone_byte(held);
			clear_flags();
			if (n_kept == 0) begin
				r.out_byte    = 8'h00;
				r.has_byte    = 1'b0;
				r.end_of_text = 1'b1;
				due_results.push_back(r);
			end else begin
				for (int k = 0; k < n_kept; k++) begin
					r.out_byte    = kept[k];
					r.has_byte    = 1'b1;
					r.end_of_text = (k == n_kept - 1);
					due_results.push_back(r);
				end
			end
		endfunction

		task report_mismatch(string what);
			mismatch_count++;
			if (mismatch_count <= PRINT_LIMIT)
				$display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		task match_result(res_item_t got);
			res_item_t want;
			results_seen++;
			if (got.has_byte === 1'b1)
				bytes_kept++;
			if (got.end_of_text === 1'b1)
				texts_ended++;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result %0d with none due: byte %02h has %b end %b",
					results_seen, got.out_byte, got.has_byte, got.end_of_text));
				return;
			end
			want = due_results.pop_front();
			if (got.out_byte !== want.out_byte)
				report_mismatch($sformatf("result %0d out_byte %02h, want %02h",
					results_seen, got.out_byte, want.out_byte));
			if (got.has_byte !== want.has_byte)
				report_mismatch($sformatf("result %0d has_byte %b, want %b",
					results_seen, got.has_byte, want.has_byte));
			if (got.end_of_text !== want.end_of_text)
				report_mismatch($sformatf("result %0d end_of_text %b, want %b",
					results_seen, got.end_of_text, want.end_of_text));
		endtask
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	src_item_t src_item  = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_item;

	stripped_stream stripped;
	logic [7:0]     text_buf[$];
	int             cycle_count  = 0;
	int             bytes_sent   = 0;
	int             texts_sent   = 0;
	int             drains       = 0;
	bit             src_calm     = 1'b0;
	bit             res_calm     = 1'b0;

	comment_strip_space_collapse_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Both channels are sampled here, at the edge, before any of this edge's
	// updates land. A source transfer is noted before a result is checked.
	// No result can come from a byte that is taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && !src_stall)
				stripped.take_source(src_item);
			if (res_valid && !res_stall)
				stripped.match_result(res_item);
		end
	end

	// The receiver alternates free runs with stall bursts, but only runs while
	// res_calm is set. No burst and no run is ever empty, so res_stall is never
	// set twice in one step.
	initial begin
		int run;
		int hold;
		forever begin
			case ($urandom_range(0, 19))
				0:         run = $urandom_range(60, 150);
				1, 2, 3,
				4, 5:      run = $urandom_range(7, 30);
				default:   run = $urandom_range(1, 6);
			endcase
			repeat (run) @(posedge clk);
			if (!res_calm) begin
				hold = $urandom_range(0, 99);
				if (hold < 80)
					hold = $urandom_range(1, 3);
				else if (hold < 97)
					hold = $urandom_range(4, 12);
				else
					hold = $urandom_range(30, 80);
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Mostly back-to-back bytes, some short gaps and the odd long one.
	function automatic int source_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	// Offers one byte and returns at the edge where it is taken. A byte
	// that follows at once keeps valid high, and only the payload moves.
	task automatic send_item(input src_item_t it);
		int gap;
		gap = src_calm ? 0 : source_gap();
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= it;
		do
			@(posedge clk);
		while (src_stall);
		bytes_sent++;
	endtask

	task automatic send_text();
		src_item_t it;
		for (int i = 0; i < text_buf.size(); i++) begin
			it.in_byte = text_buf[i];
			it.last    = (i == text_buf.size() - 1);
			send_item(it);
		end
		texts_sent++;
		text_buf.delete();
	endtask

	// Holds the source back until every result that is due has come.
	// This is called at the edge of the last transfer, so valid drops at once.
	task automatic drain_results();
		src_valid <= 1'b0;
		drains++;
		do
			@(posedge clk);
		while (stripped.due_results.size() != 0);
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	function automatic logic [7:0] blank_byte();
		int pick;
		pick = $urandom_range(9, 14);
		return (pick == 14) ? CH_SPACE : 8'(pick);
	endfunction

	// Appends one random piece of text: a word, a whitespace run, a comment,
	// a stray mark or raw noise.
	task automatic add_piece();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			n = $urandom_range(1, 6);
			repeat (n) text_buf.push_back(8'($urandom_range(33, 126)));
		end else if (kind < 50) begin
			n = $urandom_range(1, 3);
			repeat (n) text_buf.push_back(blank_byte());
		end else if (kind < 60) begin
			add_str("//");
			n = $urandom_range(0, 5);
			repeat (n) text_buf.push_back(8'($urandom_range(1, 255)));
			if ($urandom_range(0, 99) < 85)
				text_buf.push_back(CH_NEWLINE);
		end else if (kind < 72) begin
			add_str("/*");
			n = $urandom_range(0, 6);
			repeat (n) begin
				case ($urandom_range(0, 5))
					0:       text_buf.push_back(CH_STAR);
					1:       text_buf.push_back(CH_SLASH);
					2:       text_buf.push_back(CH_NEWLINE);
					default: text_buf.push_back(8'($urandom_range(1, 255)));
				endcase
			end
			if ($urandom_range(0, 99) < 85)
				add_str("*/");
		end else if (kind < 78) begin
			n = $urandom_range(1, 2);
			repeat (n) text_buf.push_back($urandom_range(0, 1) ? CH_STAR : CH_SLASH);
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) text_buf.push_back(8'($urandom_range(1, 255)));
		end
	endtask

	initial begin
		int cycle_at_start;
		cycle_at_start = 0;
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles with %0d results still due.",
			cycle_count - cycle_at_start, stripped.due_results.size());
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		int random_bytes;
		int pieces;
		random_bytes = 0;
		stripped = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Leading space, a block comment holding a line comment, a nested
		// open, a close with nothing open, and a whitespace run before the
		// end, all around the bytes on either side of the top bit.
		text_buf.push_back(CH_SPACE);
		add_str("a/*//");
		text_buf.push_back(CH_NEWLINE);
		add_str("/**/ ");
		text_buf.push_back(8'h7F);
		add_str("*/");
		text_buf.push_back(CH_TAB);
		text_buf.push_back(CH_NEWLINE);
		text_buf.push_back(8'h80);
		send_text();
		// A text that ends inside a line comment.
		text_buf.push_back(8'h01);
		add_str("//");
		send_text();
		// A text that ends inside a block comment; the next one starts clean.
		add_str("/*");
		send_text();
		text_buf.push_back(8'hFF);
		send_text();
		// A text of whitespace only gives an end result without a byte.
		text_buf.push_back(CH_CR);
		send_text();
		drain_results();

		while (random_bytes < RANDOM_ITEMS) begin
			// One stretch of texts runs with both sides at full rate.
			src_calm = (texts_sent >= 40 && texts_sent < 70);
			res_calm = src_calm;
			pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
				: $urandom_range(1, 6);
			repeat (pieces) add_piece();
			random_bytes += text_buf.size();
			send_text();
			if ($urandom_range(0, 24) == 0)
				drain_results();
		end
		src_calm = 1'b0;
		res_calm = 1'b0;

		drain_results();
		repeat (20) @(posedge clk);

		$display("Sent %0d texts, %0d bytes in all; checked %0d results, %0d kept bytes.",
			texts_sent, bytes_sent, stripped.results_seen, stripped.bytes_kept);
		$display("Ends of text seen: %0d; the source was held until empty %0d times.",
			stripped.texts_ended, drains);
		if (stripped.mismatch_count == 0 && stripped.due_results.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("%0d mismatches, %0d results never came.",
				stripped.mismatch_count, stripped.due_results.size());
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

// File: sim.f
design/ccs_pkg.sv
design/comment_strip_space_collapse_top.sv
design/ccs_checker.sv
tb/testbench.sv
